/* src/bmfnz_pkg.sv */
// shared types and constants for the block map next-nonzero search unit
package bmfnz_pkg;

    localparam int INDEX_W        = 15;
    localparam int VALUE_W        = 8;
    localparam int EBL_W          = 2;
    localparam int BYTES_W        = 13;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int BYTE_BITS_LOG2 = 3;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_FIND  = 1'b1
    } command_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_ENTRY_BITS_LOG2 = 1'b0,
        CFG_BYTES_IN_USE    = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        command_t               command;
        logic [INDEX_W-1:0]     block_index;
        logic [VALUE_W-1:0]     entry_value;
    } item_t;

    typedef struct packed
    {
        logic                   found;
        logic [INDEX_W-1:0]     next_index;
    } result_t;

endpackage

/* src/bitmap_find_next_nonzero_unit.sv */
// block map store with write and find-next-nonzero commands
//
// commands: pulse start with an item while busy is low; the item is taken at that edge.
// a write command stores one entry (1, 2, 4 or 8 bits) by read-modify-write of its
// byte: busy through a read state and then a write state, no result. a write whose byte
// lies past the store is dropped at the accepting edge and leaves busy low.
// a find command scans the map one byte per cycle through a single memory read port,
// starting at the byte holding the start index and stopping at the first nonzero
// entry or at min(bytes_in_use, MAP_BYTES). the result follows with done high for
// exactly one cycle, as busy drops, so a new command may be started in that same
// cycle.
// a start index at or past the active limit returns found = 0, next_index = 0.
// configuration: cfg_valid/cfg_ready write channel, cfg_ready always high; write
// registers only while busy is low and no result is pending.
// reset: all control state clears and a clearing pass writes zero to every map
// byte, one byte per cycle, with busy high throughout; configuration writes
// are taken during the pass. the receiver of results cannot stall.
module bitmap_find_next_nonzero_unit #(
    parameter int MAP_BYTES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bmfnz_pkg::item_t                    item,
    output logic                                done,
    output bmfnz_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmfnz_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bmfnz_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bmfnz_pkg::*;

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int PW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam logic [PW:0]   MAP_BYTES_W = (PW+1)'(MAP_BYTES);
    localparam logic [PW-1:0] LAST_BYTE   = PW'(MAP_BYTES - 1);

    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_WR_RD = 5'b00100,
        ST_WR_WR = 5'b01000,
        ST_SCAN  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [PW-1:0]        ptr_reg, ptr_next;
    logic [PW-1:0]        chk_ptr_reg, chk_ptr_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic                 chk_first_reg, chk_first_next;
    logic                 first_reg, first_next;
    logic [2:0]           off_reg, off_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [EBL_W-1:0]     ebl_reg;
    logic [BYTES_W-1:0]   bytes_in_use_reg;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic [7:0]           mem [MAP_BYTES];
    logic [7:0]           rdata_reg;
    logic                 mem_we;
    logic [7:0]           mem_wdata;

    logic [PW:0]          bytes_ext;
    logic [PW:0]          used;
    logic [INDEX_W-1:0]   start_byte;
    logic [2:0]           start_off;
    logic [7:0]           nz;
    logic [7:0]           nz_m;
    logic                 hit;
    logic [2:0]           hit_off;
    logic [PW+2:0]        hit_index;
    logic [7:0]           emask;
    logic [2:0]           wshift;
    logic [7:0]           wmask;
    logic [7:0]           merged;
    logic                 accept;

    assign accept     = start && !busy;
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign result     = result_reg;
    assign cfg_ready  = 1'b1;

    assign bytes_ext  = (PW+1)'(bytes_in_use_reg);
    assign used       = (bytes_ext > MAP_BYTES_W) ? MAP_BYTES_W : bytes_ext;
    assign start_byte = item.block_index >> (2'(BYTE_BITS_LOG2) - ebl_reg);
    assign start_off  = item.block_index[2:0] & (3'd7 >> ebl_reg);

    // per-entry nonzero flags of the byte under check
    always_comb
    begin
        nz = '0;
        unique case (ebl_reg)
            2'd0:
            begin
                nz = rdata_reg;
            end
            2'd1:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    nz[k] = |rdata_reg[2*k +: 2];
                end
            end
            2'd2:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    nz[k] = |rdata_reg[4*k +: 4];
                end
            end
            2'd3:
            begin
                nz[0] = |rdata_reg;
            end
            default:
            begin
                nz = '0;
            end
        endcase
    end

    // drop entries below the start in the first byte, then lowest set entry
    always_comb
    begin
        nz_m    = chk_first_reg ? (nz & ~((8'd1 << off_reg) - 8'd1)) : nz;
        hit     = chk_valid_reg && (nz_m != 8'd0);
        hit_off = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (nz_m[k])
            begin
                hit_off = 3'(k);
            end
        end
    end

    assign hit_index = (({3'b000, chk_ptr_reg}) << (2'(BYTE_BITS_LOG2) - ebl_reg))
                     | (PW+3)'(hit_off);

    // entry merge for writes
    always_comb
    begin
        unique case (ebl_reg)
            2'd0:    emask = 8'h01;
            2'd1:    emask = 8'h03;
            2'd2:    emask = 8'h0F;
            2'd3:    emask = 8'hFF;
            default: emask = 8'h00;
        endcase
        wshift = off_reg << ebl_reg;
        wmask  = emask << wshift;
        merged = (rdata_reg & ~wmask) | (((val_reg & emask) << wshift) & wmask);
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        chk_ptr_next   = chk_ptr_reg;
        chk_valid_next = 1'b0;
        chk_first_next = 1'b0;
        first_next     = first_reg;
        off_next       = off_reg;
        val_next       = val_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_wdata      = 8'h00;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + PW'(1);
                if (ptr_reg == LAST_BYTE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    ptr_next   = PW'(start_byte);
                    off_next   = start_off;
                    val_next   = item.entry_value;
                    first_next = 1'b1;
                    if (item.command == CMD_FIND)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if ((PW+1)'(start_byte) < MAP_BYTES_W)
                    begin
                        state_next = ST_WR_RD;
                    end
                end
            end
            ST_WR_RD:
            begin
                state_next = ST_WR_WR;
            end
            ST_WR_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = merged;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                priority if (hit)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{found: 1'b1, next_index: hit_index[INDEX_W-1:0]};
                end
                else if ({1'b0, ptr_reg} >= used)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '{found: 1'b0, next_index: '0};
                end
                else
                begin
                    chk_ptr_next   = ptr_reg;
                    chk_valid_next = 1'b1;
                    chk_first_next = first_reg;
                    first_next     = 1'b0;
                    ptr_next       = ptr_reg + PW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            ptr_reg          <= '0;
            chk_valid_reg    <= 1'b0;
            chk_first_reg    <= 1'b0;
            first_reg        <= 1'b0;
            done_reg         <= 1'b0;
            ebl_reg          <= '0;
            bytes_in_use_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            chk_valid_reg <= chk_valid_next;
            chk_first_reg <= chk_first_next;
            first_reg     <= first_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ENTRY_BITS_LOG2: ebl_reg          <= cfg_data[EBL_W-1:0];
                    CFG_BYTES_IN_USE:    bytes_in_use_reg <= cfg_data[BYTES_W-1:0];
                    default:             ebl_reg          <= ebl_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_ptr_reg <= chk_ptr_next;
        off_reg     <= off_next;
        val_reg     <= val_next;
        result_reg  <= result_next;
    end

    // map store, one port: read each cycle, written when mem_we is high
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg[AW-1:0]] <= mem_wdata;
        end
        rdata_reg <= mem[ptr_reg[AW-1:0]];
    end

endmodule

/* src/bmfnz_checker.sv */
// port-level checks for the block map search unit, bound to the top level
module bmfnz_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  bmfnz_pkg::item_t    item,
    input  logic                done,
    input  bmfnz_pkg::result_t  result
);
    import bmfnz_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.command == CMD_FIND) |=> busy)
        else $error("find command not taken");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.next_index == '0))
        else $error("none result with nonzero index");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.command == CMD_WRITE) |=> !done ##1 !done)
        else $error("write command produced a result beat");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result beat right after accept");

endmodule

bind bitmap_find_next_nonzero_unit bmfnz_checker u_bmfnz_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

/* tb/tb_top.sv */
// testbench for the block map next-nonzero search unit: mirrored map, random commands, scoreboard
module tb_top;
    import bmfnz_pkg::*;

    localparam int MAP_BYTES   = 4096;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 8;

    typedef struct {
        item_t  cmd;
        bit     drain_first;
    } queued_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    item_t                  item = '0;
    logic                   done;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    queued_cmd_t            cmd_queue[$];
    result_t                awaited_results[$];
    logic [7:0]             map_mirror [MAP_BYTES];
    logic [EBL_W-1:0]       width_log2_mirror;
    logic [BYTES_W-1:0]     bytes_used_mirror;
    int                     items_taken = 0;
    int                     stall_cycles = 0;
    int                     error_count = 0;

    bitmap_find_next_nonzero_unit #(
        .MAP_BYTES (MAP_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [7:0] entry_mask();
        return 8'((1 << (1 << width_log2_mirror)) - 1);
    endfunction

    function automatic logic [7:0] entry_at(input int unsigned idx);
        int unsigned byte_no;
        int unsigned shift;
        byte_no = idx >> (BYTE_BITS_LOG2 - width_log2_mirror);
        if (byte_no >= MAP_BYTES)
            return '0;
        shift = (idx & ((8 >> width_log2_mirror) - 1)) << width_log2_mirror;
        return (map_mirror[byte_no] >> shift) & entry_mask();
    endfunction

    function automatic void store_entry(input logic [INDEX_W-1:0] idx,
                                        input logic [VALUE_W-1:0] value);
        int unsigned byte_no;
        int unsigned shift;
        logic [7:0]  field;
        byte_no = idx >> (BYTE_BITS_LOG2 - width_log2_mirror);
        if (byte_no < MAP_BYTES)
        begin
            shift = (idx & ((8 >> width_log2_mirror) - 1)) << width_log2_mirror;
            field = entry_mask() << shift;
            map_mirror[byte_no] = (map_mirror[byte_no] & ~field)
                                | (8'(value & entry_mask()) << shift);
        end
    endfunction

    function automatic result_t next_nonzero_of(input logic [INDEX_W-1:0] from_idx);
        result_t     r;
        int unsigned used;
        int unsigned limit;
        r = '0;
        used = (bytes_used_mirror > MAP_BYTES) ? MAP_BYTES : bytes_used_mirror;
        limit = used << (BYTE_BITS_LOG2 - width_log2_mirror);
        for (int unsigned i = from_idx; i < limit; i++)
        begin
            if (entry_at(i) != 0)
            begin
                r.found = 1'b1;
                r.next_index = i[INDEX_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic void push_cmd(input command_t op, input int idx, input int value,
                                     input bit drain_first = 1'b0);
        queued_cmd_t qc;
        qc.cmd.command = op;
        qc.cmd.block_index = idx[INDEX_W-1:0];
        qc.cmd.entry_value = value[VALUE_W-1:0];
        qc.drain_first = drain_first;
        cmd_queue.push_back(qc);
    endfunction

    task automatic wait_quiet();
        while (cmd_queue.size() != 0 || start || busy || awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int ebl_word, input int used);
        wait_quiet();
        write_reg(CFG_ENTRY_BITS_LOG2, ebl_word);
        write_reg(CFG_BYTES_IN_USE, used);
    endtask

    task automatic run_random_phase(input int ebl, input int used, input int count);
        int limit;
        int roll;
        int idx;
        int value;
        // upper data bits of the width register are don't-care
        set_config(int'($urandom & 32'h1ffc) | ebl, used);
        limit = ((used > MAP_BYTES) ? MAP_BYTES : used) << (BYTE_BITS_LOG2 - ebl);
        repeat (count)
        begin
            roll = $urandom_range(99);
            value = ($urandom_range(4) == 0) ? 0 : $urandom_range(255);
            if (roll < 40)
                idx = $urandom_range(limit + 7);
            else if (roll < 45 || roll >= 88)
                idx = $urandom_range(32767);
            else
                idx = $urandom_range(limit);
            if (idx > 32767)
                idx = 32767;
            push_cmd((roll < 45) ? CMD_WRITE : CMD_FIND, idx, value,
                     $urandom_range(49) == 0);
        end
    endtask

    // driver: one beat per accepted start
    always @(posedge clk or negedge rst_n)
    begin : feed
        int          idle_pct;
        queued_cmd_t next_cmd;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || !busy)
        begin
            idle_pct = (items_taken < 300) ? 38 : (items_taken < 600) ? 69 : 0;
            if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct
                && (!cmd_queue[0].drain_first
                    || (!start && !busy && awaited_results.size() == 0)))
            begin
                next_cmd = cmd_queue.pop_front();
                item <= next_cmd.cmd;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : beat_check
        result_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENTRY_BITS_LOG2: width_log2_mirror = cfg_data[EBL_W-1:0];
                    default:             bytes_used_mirror = cfg_data[BYTES_W-1:0];
                endcase
            end

            if (done)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no find outstanding");
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b",
                                                  result.found, want.found));
                    if (result.next_index !== want.next_index)
                        report_mismatch($sformatf("next_index %0d, want %0d",
                                                  result.next_index, want.next_index));
                end
            end

            if (start && !busy)
            begin
                items_taken++;
                if (item.command == CMD_WRITE)
                    store_entry(item.block_index, item.entry_value);
                else
                    awaited_results.push_back(next_nonzero_of(item.block_index));
            end
        end
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("bitmap_find_next_nonzero_unit test failed");
        $finish;
    end

    initial
    begin : stimulus
        foreach (map_mirror[i])
            map_mirror[i] = '0;
        width_log2_mirror = '0;
        bytes_used_mirror = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: empty limit
        push_cmd(CMD_FIND, 0, 0);
        push_cmd(CMD_WRITE, 5, 1);
        push_cmd(CMD_FIND, 32767, 255);
        push_cmd(CMD_FIND, 0, 0);

        set_config(13'h1ffc, 4);
        push_cmd(CMD_FIND, 0, 0);
        push_cmd(CMD_WRITE, 5, 8'hfe);
        push_cmd(CMD_FIND, 0, 0, 1'b1);
        push_cmd(CMD_WRITE, 31, 8'hff);
        push_cmd(CMD_FIND, 6, 0);
        push_cmd(CMD_FIND, 31, 0);
        push_cmd(CMD_FIND, 32, 0);
        push_cmd(CMD_WRITE, 32767, 8'hff);
        push_cmd(CMD_WRITE, 0, 0);

        // byte-wide entries, bytes in use past the store
        set_config(3, 8191);
        push_cmd(CMD_WRITE, 32767, 8'haa);
        push_cmd(CMD_WRITE, 4096, 7);
        push_cmd(CMD_FIND, 4000, 0);
        push_cmd(CMD_FIND, 4096, 0);
        push_cmd(CMD_FIND, 0, 0);
        push_cmd(CMD_WRITE, 4095, 0);
        push_cmd(CMD_FIND, 4, 0);

        set_config(1, 2);
        push_cmd(CMD_WRITE, 6, 3);
        push_cmd(CMD_FIND, 0, 0);

        set_config(2, 1);
        push_cmd(CMD_WRITE, 1, 8'hf0);
        push_cmd(CMD_FIND, 0, 0);
        push_cmd(CMD_FIND, 1, 0);

        run_random_phase(1, 16, 110);
        run_random_phase(0, 8, 110);
        run_random_phase(2, 64, 100);
        run_random_phase(3, 200, 100);
        run_random_phase(0, 4096, 40);
        run_random_phase(3, 0, 30);
        run_random_phase(1, 8191, 40);
        run_random_phase(2, 4096, 40);
        run_random_phase(0, 1, 50);
        run_random_phase(3, 33, 90);
        run_random_phase(1, 5, 90);
        run_random_phase(2, 8191, 40);
        run_random_phase($urandom_range(3), $urandom_range(1, 48), 60);

        wait_quiet();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("bitmap_find_next_nonzero_unit test passed");
        else
            $display("bitmap_find_next_nonzero_unit test failed");
        $finish;
    end

endmodule
